// ===== sv/jpss_pkg.sv =====
// jpss_pkg: shared types, register codes and the lfsr helper of the joint pose sweep sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package jpss_pkg;

  localparam int          JOINT_CAP  = 16;
  localparam logic [31:0] LFSR_MASK  = 32'hA300_0000;
  localparam logic [16:0] COUNT_MAX  = 17'h1_FFFF;
  localparam int          CMDQ_DEPTH = 4;
  localparam int          CMDQ_AW    = 2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_JOINT_COUNT       = 3'd0,
    REG_SWEEP_MODE        = 3'd1,
    REG_DWELL_LIMIT       = 3'd2,
    REG_ELAPSED_INCREMENT = 3'd3,
    REG_RANDOM_SEED       = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TRIG = 1'b1
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DRAW,
    BK_MUL,
    BK_CALC,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    op_t                operation;
    logic               joints_done;
    logic [3:0]         joint_index;
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
    logic [14:0]        step_size;
  } in_t;

  typedef struct packed {
    logic [3:0]         target_joint;
    logic signed [15:0] target_position;
    logic               last_joint;
  } out_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [3:0]         joint_index;
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
    logic [14:0]        step_size;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  joint_count;
    logic        sweep_mode;
    logic [15:0] dwell_limit;
    logic [7:0]  elapsed_increment;
    logic        seed_load;
    logic [31:0] seed;
  } cfg_t;

  // eight steps of the right-shifting galois register
  function automatic logic [31:0] lfsr_step8(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    for (int i = 0; i < 8; i++) begin
      if (s[0]) begin
        s = (s >> 1) ^ LFSR_MASK;
      end else begin
        s = s >> 1;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/joint_pose_sweep_sequencer.sv =====
// joint_pose_sweep_sequencer: top level with the configuration registers
// depends on jpss_pkg, jpss_front, jpss_cmdq, jpss_back
//
//   port group   direction  beat accepted when
//   in_*         input      in_push  && !in_full
//   out_*        output     out_pop  && !out_empty
//   cfg_*        input      cfg_we (no wait, no read-back)
//
// the front takes one input beat per cycle while the 4-entry command queue has room
// a load only writes the joint tables; a trigger walks the joints in use, each joint through
// calc and emit in sweep mode, or through lfsr draw, multiply, add and emit in random mode
// the back walk over the joint tables sets the rate; a stalled out_pop holds the walk
// reset is synchronous active low, no clearing pass; commanded targets reset to zero
`default_nettype none

module joint_pose_sweep_sequencer
  import jpss_pkg::*;
#(
  parameter int MAX_JOINTS = 16
)
(
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_push,
  output logic              in_full,
  input  wire  in_t         in_data,
  output logic              out_empty,
  input  wire  logic        out_pop,
  output out_t              out_data,
  input  wire  logic        cfg_we,
  input  wire  logic [2:0]  cfg_index,
  input  wire  logic [31:0] cfg_wdata
);

  cfg_t        cfg;
  logic [4:0]  joint_count_r;
  logic        sweep_mode_r;
  logic [15:0] dwell_limit_r;
  logic [7:0]  elapsed_inc_r;
  logic        seed_load;

  logic        q_full;
  logic        q_push;
  cmd_t        q_push_data;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= 5'd1;
      sweep_mode_r  <= 1'b0;
      dwell_limit_r <= 16'd10;
      elapsed_inc_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_JOINT_COUNT:       joint_count_r <= cfg_wdata[4:0];
        REG_SWEEP_MODE:        sweep_mode_r  <= cfg_wdata[0];
        REG_DWELL_LIMIT:       dwell_limit_r <= cfg_wdata[15:0];
        REG_ELAPSED_INCREMENT: elapsed_inc_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // the seed is not kept; a write reloads the lfsr directly
  assign seed_load = cfg_we && (reg_idx_t'(cfg_index) == REG_RANDOM_SEED);

  assign cfg.joint_count       = joint_count_r;
  assign cfg.sweep_mode        = sweep_mode_r;
  assign cfg.dwell_limit       = dwell_limit_r;
  assign cfg.elapsed_increment = elapsed_inc_r;
  assign cfg.seed_load         = seed_load;
  assign cfg.seed              = cfg_wdata;

  assign in_full = q_full;

  jpss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_full   (q_full),
    .cmd_push (q_push),
    .cmd_data (q_push_data)
  );

  jpss_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  jpss_back #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/jpss_front.sv =====
// jpss_front: accepts input beats, keeps the dwell counter and turns items into commands
// depends on jpss_pkg
`default_nettype none

module jpss_front
  import jpss_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  cfg_t cfg,
  input  wire  logic in_push,
  input  wire  in_t  in_data,
  input  wire  logic q_full,
  output logic       cmd_push,
  output cmd_t       cmd_data
);

  logic [16:0] dwell_r;
  logic [16:0] dwell_nxt;
  logic [17:0] dwell_sum;
  logic [16:0] dwell_sat;
  logic        accept;
  logic        trig;

  assign accept    = in_push && !q_full;
  assign dwell_sum = {1'b0, dwell_r} + {10'd0, cfg.elapsed_increment};
  assign dwell_sat = dwell_sum[17] ? COUNT_MAX : dwell_sum[16:0];

  always_comb begin
    dwell_nxt = dwell_r;
    trig      = 1'b0;
    if (accept && in_data.operation == OP_TICK) begin
      if (in_data.joints_done) begin
        dwell_nxt = dwell_sat;
      end
      if (dwell_nxt > {1'b0, cfg.dwell_limit}) begin
        trig      = 1'b1;
        dwell_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= '0;
    end else begin
      dwell_r <= dwell_nxt;
    end
  end

  assign cmd_push             = accept && (in_data.operation == OP_LOAD || trig);
  assign cmd_data.kind        = (in_data.operation == OP_LOAD) ? CMD_LOAD : CMD_TRIG;
  assign cmd_data.joint_index = in_data.joint_index;
  assign cmd_data.lower_bound = in_data.lower_bound;
  assign cmd_data.upper_bound = in_data.upper_bound;
  assign cmd_data.step_size   = in_data.step_size;

  a_trig_clears: assert property (@(posedge clk) disable iff (!rst_n)
    trig |=> dwell_r == '0)
    else $error("dwell counter not cleared after trigger");

endmodule

`default_nettype wire

// ===== sv/jpss_cmdq.sv =====
// jpss_cmdq: short command queue between the front and the back
// depends on jpss_pkg
`default_nettype none

module jpss_cmdq
  import jpss_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic push,
  input  wire  cmd_t push_data,
  input  wire  logic pop,
  output logic       full,
  output logic       valid,
  output cmd_t       head
);

  cmd_t                 entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r;
  logic [CMDQ_AW-1:0]   rd_ptr_r;
  logic [CMDQ_AW:0]     count_r;

  assign full  = count_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign valid = count_r != '0;
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (CMDQ_AW+1)'(CMDQ_DEPTH))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("command queue popped while empty");

endmodule

`default_nettype wire

// ===== sv/jpss_back.sv =====
// jpss_back: joint tables, target generation walk, lfsr and the result register
// depends on jpss_pkg
`default_nettype none

module jpss_back
  import jpss_pkg::*;
#(
  parameter int MAX_JOINTS = 16
)
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  cfg_t cfg,
  input  wire  logic cmd_valid,
  input  wire  cmd_t cmd,
  output logic       cmd_pop,
  input  wire  logic out_pop,
  output logic       out_empty,
  output out_t       out_data
);

  localparam int DEPTH = (MAX_JOINTS < JOINT_CAP) ? MAX_JOINTS : JOINT_CAP;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [15:0] lower_tab [DEPTH];
  logic signed [15:0] upper_tab [DEPTH];
  logic [14:0]        step_tab  [DEPTH];
  logic signed [15:0] cmd_tab_r [DEPTH];

  bk_state_t          state_r, state_nxt;
  logic [3:0]         j_r, j_nxt;
  logic [4:0]         n_r, n_nxt;
  logic               carry_r, carry_nxt;
  logic               started_r, started_nxt;
  logic               ph_r, ph_nxt;
  logic [31:0]        lfsr_r, lfsr_nxt;
  logic signed [15:0] lo_r, lo_nxt;
  logic [16:0]        span_r, span_nxt;
  logic [32:0]        prod_r, prod_nxt;
  logic signed [15:0] pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic               tab_we;
  logic               cmdtab_we;
  logic [IW-1:0]      jx;
  logic signed [15:0] low_j, up_j, cur_j;
  logic [14:0]        step_j;
  logic signed [15:0] min_j, max_j;
  logic signed [17:0] sw_sum;
  logic signed [17:0] rnd_sum;
  logic [4:0]         n_cfg;
  logic               last;
  logic               slot_free;

  assign jx     = j_r[IW-1:0];
  assign low_j  = lower_tab[jx];
  assign up_j   = upper_tab[jx];
  assign step_j = step_tab[jx];
  assign cur_j  = cmd_tab_r[jx];
  assign min_j  = (low_j < up_j) ? low_j : up_j;
  assign max_j  = (low_j < up_j) ? up_j : low_j;

  assign sw_sum  = {{2{cur_j[15]}}, cur_j} + {3'b000, step_j};
  assign rnd_sum = {{2{lo_r[15]}}, lo_r} + {1'b0, prod_r[32:16]};

  assign n_cfg     = (cfg.joint_count > 5'(DEPTH)) ? 5'(DEPTH) : cfg.joint_count;
  assign last      = ({1'b0, j_r} + 5'd1) == n_r;
  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    carry_nxt     = carry_r;
    started_nxt   = started_r;
    ph_nxt        = ph_r;
    lfsr_nxt      = lfsr_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    tab_we        = 1'b0;
    cmdtab_we     = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_LOAD) begin
            tab_we = {1'b0, cmd.joint_index} < 5'(DEPTH);
          end else begin
            j_nxt     = '0;
            n_nxt     = n_cfg;
            carry_nxt = 1'b1;
            ph_nxt    = 1'b0;
            if (n_cfg == '0) begin
              started_nxt = 1'b1;
            end else begin
              state_nxt = cfg.sweep_mode ? BK_CALC : BK_DRAW;
            end
          end
        end
      end
      BK_DRAW: begin
        // sixteen lfsr steps per joint, eight per cycle
        lfsr_nxt = lfsr_step8(lfsr_r);
        ph_nxt   = 1'b1;
        if (!ph_r) begin
          lo_nxt   = min_j;
          span_nxt = 17'({max_j[15], max_j} - {min_j[15], min_j} + 17'd1);
        end else begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_nxt  = span_r * {17'd0, lfsr_r[15:0]};
        state_nxt = BK_CALC;
      end
      BK_CALC: begin
        if (!cfg.sweep_mode) begin
          pos_nxt = rnd_sum[15:0];
        end else if (!started_r) begin
          pos_nxt = low_j;
        end else if (carry_r) begin
          // odometer: wrap to the lower limit and carry on
          if (sw_sum > $signed({{2{up_j[15]}}, up_j})) begin
            pos_nxt   = low_j;
            carry_nxt = 1'b1;
          end else begin
            pos_nxt   = sw_sum[15:0];
            carry_nxt = 1'b0;
          end
        end else begin
          pos_nxt = cur_j;
        end
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.target_joint    = j_r;
          out_nxt.target_position = pos_r;
          out_nxt.last_joint      = last;
          cmdtab_we               = 1'b1;
          if (last) begin
            started_nxt = 1'b1;
            state_nxt   = BK_IDLE;
          end else begin
            j_nxt     = j_r + 4'd1;
            ph_nxt    = 1'b0;
            state_nxt = cfg.sweep_mode ? BK_CALC : BK_DRAW;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (cfg.seed_load) begin
      lfsr_nxt = (cfg.seed == '0) ? 32'd1 : cfg.seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      lfsr_r      <= 32'd1;
      j_r         <= '0;
      n_r         <= '0;
      carry_r     <= 1'b0;
      ph_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      lfsr_r      <= lfsr_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      carry_r     <= carry_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    span_r <= span_nxt;
    prod_r <= prod_nxt;
    pos_r  <= pos_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      lower_tab[cmd.joint_index[IW-1:0]] <= cmd.lower_bound;
      upper_tab[cmd.joint_index[IW-1:0]] <= cmd.upper_bound;
      step_tab[cmd.joint_index[IW-1:0]]  <= cmd.step_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        cmd_tab_r[i] <= '0;
      end
    end else if (cmdtab_we) begin
      cmd_tab_r[jx] <= pos_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> ({1'b0, j_r} < n_r))
    else $error("joint walk past joint count");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT && slot_free) |=> out_valid_r)
    else $error("result not loaded on emit");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == BK_IDLE && cmd_valid))
    else $error("command taken while busy");

endmodule

`default_nettype wire

// ===== verif/joint_pose_sweep_sequencer_tb.sv =====
// testbench for joint_pose_sweep_sequencer: table loads, dwell ticks and target beats
// depends on jpss_pkg and the rtl of the block; a scoreboard class predicts every target beat
module joint_pose_sweep_sequencer_tb;
  import jpss_pkg::*;

  localparam int          SETTLE_CYCLES = 100;
  localparam int          PRINT_CAP     = 40;
  localparam logic [4:0]  ALL_REGS      = 5'h1f;

  typedef struct {
    logic [4:0]  joint_count;
    logic        sweep_mode;
    logic [15:0] dwell_limit;
    logic [7:0]  elapsed_inc;
    logic [31:0] seed;
    logic [4:0]  write_mask;
  } reg_set_t;

  class pose_tracker;
    int   joint_count;
    int   sweep_mode;
    int   dwell_limit;
    int   elapsed_inc;
    int   dwell_count;
    bit   sweep_started;
    int   commanded[JOINT_CAP];
    int   lower_lim[JOINT_CAP];
    int   upper_lim[JOINT_CAP];
    int   step_len[JOINT_CAP];
    logic [31:0] lfsr;
    out_t pending_targets[$];
    int   errors;
    int   beats_in;
    int   targets_seen;
    int   triggers;

    function new();
      joint_count   = 1;
      sweep_mode    = 0;
      dwell_limit   = 10;
      elapsed_inc   = 1;
      dwell_count   = 0;
      sweep_started = 1'b0;
      lfsr          = 32'd1;
      foreach (commanded[j]) begin
        commanded[j] = 0;
        lower_lim[j] = 0;
        upper_lim[j] = 0;
        step_len[j]  = 0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_JOINT_COUNT:       joint_count = value[4:0];
        REG_SWEEP_MODE:        sweep_mode = value[0];
        REG_DWELL_LIMIT:       dwell_limit = value[15:0];
        REG_ELAPSED_INCREMENT: elapsed_inc = value[7:0];
        REG_RANDOM_SEED:       lfsr = (value == 32'd0) ? 32'd1 : value;
        default: ;
      endcase
    endfunction

    // sixteen shifts of the galois register per joint
    function logic [15:0] next_draw();
      for (int i = 0; i < 16; i++) begin
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
      end
      return lfsr[15:0];
    endfunction

    function void note_command(in_t beat);
      int     n;
      int     lo;
      int     hi;
      int     next_pos;
      longint span;
      bit     carry;
      out_t   res;
      beats_in++;
      if (beat.operation == OP_LOAD) begin
        lower_lim[beat.joint_index] = $signed(beat.lower_bound);
        upper_lim[beat.joint_index] = $signed(beat.upper_bound);
        step_len[beat.joint_index]  = beat.step_size;
        return;
      end
      if (beat.joints_done) begin
        dwell_count = dwell_count + elapsed_inc;
        if (dwell_count > int'(COUNT_MAX)) dwell_count = COUNT_MAX;
      end
      if (dwell_count <= dwell_limit) return;
      dwell_count = 0;
      triggers++;
      n = (joint_count > JOINT_CAP) ? JOINT_CAP : joint_count;
      carry = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (sweep_mode == 0) begin
          lo = (lower_lim[j] < upper_lim[j]) ? lower_lim[j] : upper_lim[j];
          hi = (lower_lim[j] < upper_lim[j]) ? upper_lim[j] : lower_lim[j];
          span = hi - lo + 1;
          commanded[j] = lo + int'((span * next_draw()) >> 16);
        end else if (!sweep_started) begin
          commanded[j] = lower_lim[j];
        end else if (carry) begin
          // odometer: wrap to the lower limit and carry into the next joint
          next_pos = commanded[j] + step_len[j];
          carry = 1'b0;
          if (next_pos > upper_lim[j]) begin
            next_pos = lower_lim[j];
            carry = 1'b1;
          end
          commanded[j] = next_pos;
        end
        res.target_joint    = 4'(j);
        res.target_position = 16'(commanded[j]);
        res.last_joint      = (j + 1 == n);
        pending_targets.push_back(res);
      end
      sweep_started = 1'b1;
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", what);
    endtask

    task check_target(out_t got);
      out_t want;
      targets_seen++;
      if (pending_targets.size() == 0) begin
        report($sformatf("target beat with nothing pending: joint %0d position %0d last %0d",
                         got.target_joint, got.target_position, got.last_joint));
        return;
      end
      want = pending_targets.pop_front();
      if (got.target_joint !== want.target_joint)
        report($sformatf("target_joint %0d, want %0d", got.target_joint, want.target_joint));
      if (got.target_position !== want.target_position)
        report($sformatf("joint %0d target_position %0d, want %0d", want.target_joint,
                         got.target_position, want.target_position));
      if (got.last_joint !== want.last_joint)
        report($sformatf("joint %0d last_joint %0d, want %0d", want.target_joint,
                         got.last_joint, want.last_joint));
    endtask

    function int pending();
      return pending_targets.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_t         in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  pose_tracker sb = new();
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          pop_hold = 0;

  joint_pose_sweep_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: short stalls mostly, a long one now and then, calm stretches with none
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if (!rx_calm && $urandom_range(0, 5) == 0)
        pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_command(in_data);
      if (out_pop && !out_empty) sb.check_target(out_data);
    end
  end

  function automatic int pick_gap();
    int roll;
    if (tx_calm) return 0;
    roll = $urandom_range(0, 19);
    if (roll == 0) return $urandom_range(15, 60);
    if (roll < 12) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic in_t fixed_load(int idx, int lower, int upper, int step);
    in_t beat;
    beat             = '0;
    beat.operation   = OP_LOAD;
    beat.joint_index = 4'(idx);
    beat.lower_bound = 16'(lower);
    beat.upper_bound = 16'(upper);
    beat.step_size   = 15'(step);
    return beat;
  endfunction

  // mostly ordered limits with a step that fits the range, sometimes pure noise
  function automatic in_t make_load(int idx);
    in_t beat;
    int  span;
    int  lo;
    int  step;
    beat = fixed_load(idx, 0, 0, 0);
    beat.joints_done = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      beat.lower_bound = 16'($urandom);
      beat.upper_bound = 16'($urandom);
      beat.step_size   = 15'($urandom);
    end else begin
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
      lo   = int'($urandom_range(0, 65535 - span)) - 32768;
      step = span / int'($urandom_range(2, 6)) + int'($urandom_range(0, 1));
      if (step > 32767) step = 32767;
      beat.lower_bound = 16'(lo);
      beat.upper_bound = 16'(lo + span);
      beat.step_size   = 15'(step);
    end
    return beat;
  endfunction

  function automatic in_t make_tick(logic done);
    in_t beat;
    beat.operation   = OP_TICK;
    beat.joints_done = done;
    beat.joint_index = 4'($urandom);
    beat.lower_bound = 16'($urandom);
    beat.upper_bound = 16'($urandom);
    beat.step_size   = 15'($urandom);
    return beat;
  endfunction

  function automatic reg_set_t make_settings(logic [4:0] count, logic mode, logic [15:0] limit,
                                             logic [7:0] inc, logic [31:0] seed,
                                             logic [4:0] mask);
    reg_set_t s;
    s.joint_count = count;
    s.sweep_mode  = mode;
    s.dwell_limit = limit;
    s.elapsed_inc = inc;
    s.seed        = seed;
    s.write_mask  = mask;
    return s;
  endfunction

  function automatic reg_set_t random_settings();
    int         pick;
    logic [4:0] count;
    pick = $urandom_range(0, 9);
    if (pick == 0) count = 5'd0;
    else if (pick == 1) count = 5'($urandom_range(17, 31));
    else count = 5'($urandom_range(1, 16));
    return make_settings(count, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 300))
                                                     : 16'($urandom_range(0, 6)),
                         ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'($urandom_range(1, 3)),
                         ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom),
                         5'($urandom_range(1, 31)));
  endfunction

  task automatic push_beat(in_t beat, int gap);
    in_data <= beat;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every predicted target beat is back, then let the block drain
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic apply_config(reg_set_t s);
    if (s.write_mask[REG_JOINT_COUNT]) set_reg(REG_JOINT_COUNT, 32'(s.joint_count));
    if (s.write_mask[REG_SWEEP_MODE]) set_reg(REG_SWEEP_MODE, 32'(s.sweep_mode));
    if (s.write_mask[REG_DWELL_LIMIT]) set_reg(REG_DWELL_LIMIT, 32'(s.dwell_limit));
    if (s.write_mask[REG_ELAPSED_INCREMENT])
      set_reg(REG_ELAPSED_INCREMENT, 32'(s.elapsed_inc));
    if (s.write_mask[REG_RANDOM_SEED]) set_reg(REG_RANDOM_SEED, s.seed);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int count, bit hold_mid);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) push_beat(make_load($urandom_range(0, 15)), pick_gap());
      else push_beat(make_tick(roll >= 22), pick_gap());
      if (hold_mid && k == count / 2) settle();
    end
  endtask

  initial begin
    int phases;
    phases = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every joint entry is loaded before the first trigger can read it
    push_beat(fixed_load(0, -32768, 32767, 32767), pick_gap());
    push_beat(fixed_load(1, 32767, -32768, 0), pick_gap());
    push_beat(fixed_load(2, -1, -1, 1), pick_gap());
    for (int j = 3; j < JOINT_CAP; j++) push_beat(make_load(j), pick_gap());
    // reset settings: one joint, random targets, trigger on the eleventh counted tick
    push_beat(make_tick(1'b0), pick_gap());
    repeat (11) push_beat(make_tick(1'b1), pick_gap());

    // sweep of all joints, zero dwell limit, zero seed
    settle();
    apply_config(make_settings(5'd16, 1'b1, 16'd0, 8'd255, 32'd0, ALL_REGS));
    push_beat(make_tick(1'b0), pick_gap());
    repeat (5) push_beat(make_tick(1'b1), pick_gap());

    // no joints in use: triggers clear the counter and emit nothing
    settle();
    apply_config(make_settings(5'd0, 1'b1, 16'd0, 8'd1, 32'd0,
                               ALL_REGS & ~(5'b1 << REG_RANDOM_SEED)));
    repeat (2) push_beat(make_tick(1'b1), pick_gap());

    // oversized joint count, widest limit; the counter builds up below it
    settle();
    apply_config(make_settings(5'd31, 1'b0, 16'hffff, 8'd255, 32'hffff_ffff, ALL_REGS));
    repeat (6) push_beat(make_tick(1'b1), pick_gap());

    // lowering the limit under the held count fires even without joints done
    settle();
    apply_config(make_settings(5'd0, 1'b0, 16'd1000, 8'd0, 32'd0,
                               5'b1 << REG_DWELL_LIMIT));
    push_beat(make_tick(1'b0), pick_gap());

    // zero increment never moves the counter
    settle();
    apply_config(make_settings(5'd0, 1'b0, 16'd0, 8'd0, 32'd0,
                               (5'b1 << REG_DWELL_LIMIT) | (5'b1 << REG_ELAPSED_INCREMENT)));
    repeat (2) push_beat(make_tick(1'b1), pick_gap());

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      apply_config(random_settings());
      tx_calm = ($urandom_range(0, 3) == 0);
      run_phase(25, ph == 2);
      phases++;
    end

    settle();
    $display("summary: %0d input beats, %0d target beats from %0d triggers",
             sb.beats_in, sb.targets_seen, sb.triggers);
    $display("summary: sweep and random targets, joint counts 0 to 31, %0d random settings",
             phases);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout waiting for target beats");
    $display("status: fail");
    $finish;
  end

endmodule
